// ===== hdl/lacm_pkg.sv =====
package lacm_pkg;

    localparam int LACM_FRAC_BITS   = 16;
    localparam int LACM_COORD_WIDTH = 32;
    localparam int W_WIDTH          = 17;
    localparam int SQRT_STEPS       = 32;
    localparam int CROSS_LAT        = 3;

    typedef enum logic [1:0] {
        ROW_RIGHT,
        ROW_UP,
        ROW_BACK,
        ROW_POS
    } t_row;

    function automatic int norm_lat(input int frac_bits);
        return 5 + SQRT_STEPS + 1 + (frac_bits + 1) + 1;
    endfunction

endpackage

// ===== hdl/lacm_delay.sv =====
module lacm_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// ===== hdl/lacm_norm.sv =====
module lacm_norm #(
    parameter int FRAC_BITS   = lacm_pkg::LACM_FRAC_BITS,
    parameter int COORD_WIDTH = lacm_pkg::LACM_COORD_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [2:0][COORD_WIDTH-1:0] i_vec,
    output logic [2:0][COORD_WIDTH-1:0] o_unit,
    output logic                        o_nonzero
);

    import lacm_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int SHN = (CW > 32) ? CW - 32 : 0;
    localparam int QB  = F + 1;
    localparam int NW  = F + 33;
    localparam int EW  = QB + CW + 1;
    localparam logic [EW-1:0] POS_LIM = EW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [CW-1:0] MAX_V   = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MIN_V   = {1'b1, {(CW-1){1'b0}}};

    logic [2:0][CW-1:0] mag_c;
    logic [4:0]         sh_c;
    logic [2:0][31:0]   r_m1, r_m2, r_m3, r_m4;
    logic [2:0]         r_n1, r_n2, r_n3, r_n4;
    logic [2:0][63:0]   r_sq;
    logic [63:0]        r_s3, r_s4;
    logic               r_z3, r_z4;
    logic [4:0]         k_c, r_k4;

    logic [63:0]      r_x  [SQRT_STEPS+1];
    logic [63:0]      r_r  [SQRT_STEPS+1];
    logic [2:0][31:0] r_mq [SQRT_STEPS+1];
    logic [2:0]       r_nq [SQRT_STEPS+1];
    logic [4:0]       r_kq [SQRT_STEPS+1];
    logic             r_zq [SQRT_STEPS+1];

    logic [2:0][NW-1:0] r_rem [QB+1];
    logic [2:0][QB-1:0] r_q   [QB+1];
    logic [31:0]        r_den [QB+1];
    logic [2:0]         r_nd  [QB+1];
    logic               r_zd  [QB+1];

    logic [2:0][CW-1:0] r_unit;
    logic               r_nz;

    always_comb begin
        sh_c = '0;
        for (int i = 0; i < 3; i++) begin
            mag_c[i] = i_vec[i][CW-1] ? CW'(-i_vec[i]) : i_vec[i];
        end
        for (int s = 0; s < SHN; s++) begin
            if (((64'(mag_c[0]) >> s) > (64'd1 << 31)) ||
                ((64'(mag_c[1]) >> s) > (64'd1 << 31)) ||
                ((64'(mag_c[2]) >> s) > (64'd1 << 31))) begin
                sh_c = sh_c + 5'd1;
            end
        end
    end

    always_comb begin
        k_c = '0;
        for (int t = 1; t < 32; t++) begin
            k_c = k_c + 5'(r_s3 < (64'd1 << (64 - 2 * t)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m1[i] <= 32'(64'(mag_c[i]) >> sh_c);
                r_n1[i] <= i_vec[i][CW-1];
                r_sq[i] <= {32'd0, r_m1[i]} * {32'd0, r_m1[i]};
            end
            r_m2 <= r_m1;
            r_n2 <= r_n1;
            r_s3 <= r_sq[0] + r_sq[1] + r_sq[2];
            r_z3 <= |(r_sq[0] | r_sq[1] | r_sq[2]);
            r_m3 <= r_m2;
            r_n3 <= r_n2;
            r_s4 <= r_s3;
            r_k4 <= k_c;
            r_z4 <= r_z3;
            r_m4 <= r_m3;
            r_n4 <= r_n3;
            r_x[0]  <= r_s4 << {r_k4, 1'b0};
            r_r[0]  <= '0;
            r_mq[0] <= r_m4;
            r_nq[0] <= r_n4;
            r_kq[0] <= r_k4;
            r_zq[0] <= r_z4;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] trial;
        assign trial = r_r[j] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_x[j] >= trial) begin
                    r_x[j+1] <= r_x[j] - trial;
                    r_r[j+1] <= (r_r[j] >> 1) + BIT;
                end else begin
                    r_x[j+1] <= r_x[j];
                    r_r[j+1] <= r_r[j] >> 1;
                end
                r_mq[j+1] <= r_mq[j];
                r_nq[j+1] <= r_nq[j];
                r_kq[j+1] <= r_kq[j];
                r_zq[j+1] <= r_zq[j];
            end
        end
    end

    logic [31:0] root;
    assign root = r_r[SQRT_STEPS][31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= NW'((NW + 32)'(r_mq[SQRT_STEPS][i])
                               << (7'(F) + 7'(r_kq[SQRT_STEPS])))
                               + NW'(root >> 1);
            end
            r_q[0]   <= '0;
            r_den[0] <= root;
            r_nd[0]  <= r_nq[SQRT_STEPS];
            r_zd[0]  <= r_zq[SQRT_STEPS];
        end
    end

    for (genvar b = 0; b < QB; b++) begin : g_div
        logic [NW-1:0] sub;
        assign sub = NW'(r_den[b]) << (QB - 1 - b);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[b][i] >= sub) begin
                        r_rem[b+1][i] <= r_rem[b][i] - sub;
                        r_q[b+1][i]   <= r_q[b][i] | (QB'(1) << (QB - 1 - b));
                    end else begin
                        r_rem[b+1][i] <= r_rem[b][i];
                        r_q[b+1][i]   <= r_q[b][i];
                    end
                end
                r_den[b+1] <= r_den[b];
                r_nd[b+1]  <= r_nd[b];
                r_zd[b+1]  <= r_zd[b];
            end
        end
    end

    logic [2:0][CW-1:0] val_c;
    logic [2:0][EW-1:0] qx;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qx[i] = EW'(r_q[QB][i]);
            if (!r_nd[QB][i]) begin
                val_c[i] = (qx[i] > POS_LIM) ? MAX_V : CW'(qx[i]);
            end else begin
                val_c[i] = (qx[i] > POS_LIM + EW'(1)) ? MIN_V : CW'(EW'(0) - qx[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit <= r_zd[QB] ? val_c : '0;
            r_nz   <= r_zd[QB];
        end
    end

    assign o_unit    = r_unit;
    assign o_nonzero = r_nz;

endmodule

// ===== hdl/lacm_cross.sv =====
module lacm_cross #(
    parameter int FRAC_BITS   = lacm_pkg::LACM_FRAC_BITS,
    parameter int COORD_WIDTH = lacm_pkg::LACM_COORD_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [2:0][COORD_WIDTH-1:0] i_a,
    input  logic [2:0][COORD_WIDTH-1:0] i_b,
    output logic [2:0][COORD_WIDTH-1:0] o_c
);

    import lacm_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int UW = (CW < F + 2) ? CW : F + 2;
    localparam int DW = 2 * UW + 1;
    localparam int EW = DW + 1 + CW;
    localparam logic [EW-1:0] POS_LIM = EW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [CW-1:0] MAX_V   = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MIN_V   = {1'b1, {(CW-1){1'b0}}};

    logic signed [UW-1:0]   a0, a1, a2, b0, b1, b2;
    logic signed [2*UW-1:0] r_p [6];
    logic signed [DW-1:0]   r_d [3];
    logic [2:0][CW-1:0]     r_c;
    logic [2:0][DW-1:0]     mag_c;
    logic [2:0][EW-1:0]     rnd_c;
    logic [2:0][CW-1:0]     val_c;

    assign a0 = $signed(i_a[0][UW-1:0]);
    assign a1 = $signed(i_a[1][UW-1:0]);
    assign a2 = $signed(i_a[2][UW-1:0]);
    assign b0 = $signed(i_b[0][UW-1:0]);
    assign b1 = $signed(i_b[1][UW-1:0]);
    assign b2 = $signed(i_b[2][UW-1:0]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_c[i] = r_d[i][DW-1] ? DW'(-r_d[i]) : DW'(r_d[i]);
            rnd_c[i] = (EW'(mag_c[i]) + (EW'(1) << (F - 1))) >> F;
            if (!r_d[i][DW-1]) begin
                val_c[i] = (rnd_c[i] > POS_LIM) ? MAX_V : CW'(rnd_c[i]);
            end else begin
                val_c[i] = (rnd_c[i] > POS_LIM + EW'(1)) ? MIN_V
                                                       : CW'(EW'(0) - rnd_c[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= a1 * b2;
            r_p[1] <= a2 * b1;
            r_p[2] <= a2 * b0;
            r_p[3] <= a0 * b2;
            r_p[4] <= a0 * b1;
            r_p[5] <= a1 * b0;
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= DW'(r_p[2*i]) - DW'(r_p[2*i+1]);
            end
            r_c <= val_c;
        end
    end

    assign o_c = r_c;

endmodule

// ===== hdl/lacm_rowout.sv =====
module lacm_rowout #(
    parameter int FRAC_BITS   = lacm_pkg::LACM_FRAC_BITS,
    parameter int COORD_WIDTH = lacm_pkg::LACM_COORD_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [3:0][2:0][COORD_WIDTH-1:0] i_rows,
    input  logic                             i_degen,
    output logic                             o_take,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [1:0]                       o_row_index,
    output logic signed [COORD_WIDTH-1:0]    o_elem_x,
    output logic signed [COORD_WIDTH-1:0]    o_elem_y,
    output logic signed [COORD_WIDTH-1:0]    o_elem_z,
    output logic [lacm_pkg::W_WIDTH-1:0]     o_elem_w,
    output logic                             o_last_row,
    output logic                             o_degenerate
);

    import lacm_pkg::*;

    localparam logic [W_WIDTH-1:0] W_ONE = W_WIDTH'(64'd1 << FRAC_BITS);

    logic                             r_nxt_v, n_nxt_v;
    logic                             r_cur_v, n_cur_v;
    t_row                             r_row, n_row;
    logic [3:0][2:0][COORD_WIDTH-1:0] r_nxt_rows, r_cur_rows;
    logic                             r_nxt_deg, r_cur_deg;
    logic                             cur_load, nxt_load;

    always_comb begin
        nxt_load = i_valid && !r_nxt_v;
        cur_load = r_nxt_v && (!r_cur_v || (r_row == ROW_POS && !i_stall));
        n_nxt_v  = r_nxt_v;
        n_cur_v  = r_cur_v;
        n_row    = r_row;
        if (cur_load) begin
            n_nxt_v = 1'b0;
        end else if (nxt_load) begin
            n_nxt_v = 1'b1;
        end
        if (cur_load) begin
            n_cur_v = 1'b1;
            n_row   = ROW_RIGHT;
        end else if (r_cur_v && !i_stall) begin
            if (r_row == ROW_POS) begin
                n_cur_v = 1'b0;
            end else begin
                n_row = t_row'(r_row + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nxt_v <= 1'b0;
            r_cur_v <= 1'b0;
            r_row   <= ROW_RIGHT;
        end else begin
            r_nxt_v <= n_nxt_v;
            r_cur_v <= n_cur_v;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nxt_load) begin
            r_nxt_rows <= i_rows;
            r_nxt_deg  <= i_degen;
        end
        if (cur_load) begin
            r_cur_rows <= r_nxt_rows;
            r_cur_deg  <= r_nxt_deg;
        end
    end

    assign o_take       = !r_nxt_v;
    assign o_valid      = r_cur_v;
    assign o_row_index  = r_row;
    assign o_elem_x     = r_cur_rows[r_row][0];
    assign o_elem_y     = r_cur_rows[r_row][1];
    assign o_elem_z     = r_cur_rows[r_row][2];
    assign o_elem_w     = (r_row == ROW_POS) ? W_ONE : '0;
    assign o_last_row   = (r_row == ROW_POS);
    assign o_degenerate = r_cur_deg;

endmodule

// ===== hdl/look_at_camera_matrix_core.sv =====
// Look-at camera matrix. One input beat carries the camera position, the
// target point and the up hint; the block answers with four output beats,
// the rows right, up, back and position of the camera-to-world matrix,
// in that order, with last_row set on the position row.
// Both channels use valid and stall. The input is taken whenever o_stall is
// low, so beats may arrive on consecutive cycles until the row buffers fill.
// Each input beat yields four output beats, so the four-row output port sets
// the sustained rate; new items enter while earlier ones are in flight.
// The path from an input beat to its first row runs through two normalisers,
// each a 32-stage square root followed by a divider with one quotient bit per
// stage, and two three-stage cross-product units.
// A stall on the output holds the row being sent; nothing is lost or
// repeated. The pipeline is held while the row buffer holding the next item
// is full, which raises o_stall.
// Reset empties the pipeline and the row buffers; the block holds no other
// state. A zero-length vector raises degenerate and zeroes rows 0 to 2.
module look_at_camera_matrix_core #(
    parameter int FRAC_BITS   = lacm_pkg::LACM_FRAC_BITS,
    parameter int COORD_WIDTH = lacm_pkg::LACM_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_cam_x,
    input  logic signed [COORD_WIDTH-1:0] i_cam_y,
    input  logic signed [COORD_WIDTH-1:0] i_cam_z,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_z,
    input  logic signed [COORD_WIDTH-1:0] i_hint_x,
    input  logic signed [COORD_WIDTH-1:0] i_hint_y,
    input  logic signed [COORD_WIDTH-1:0] i_hint_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_row_index,
    output logic signed [COORD_WIDTH-1:0] o_elem_x,
    output logic signed [COORD_WIDTH-1:0] o_elem_y,
    output logic signed [COORD_WIDTH-1:0] o_elem_z,
    output logic [lacm_pkg::W_WIDTH-1:0]  o_elem_w,
    output logic                          o_last_row,
    output logic                          o_degenerate
);

    import lacm_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NL = norm_lat(FRAC_BITS);
    localparam int CL = CROSS_LAT;
    localparam int T  = 2 * NL + 2 * CL;
    localparam logic [CW-1:0] MAX_V = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MIN_V = {1'b1, {(CW-1){1'b0}}};

    logic               en;
    logic               r_va;
    logic               r_vp [T];
    logic [2:0][CW-1:0] r_cam, r_dvec, r_hvec;
    logic [2:0][CW-1:0] cam_c, tgt_c, d_c;
    logic [2:0][CW:0]   diff_c;

    logic [2:0][CW-1:0] dir_u, up_u, rraw, right_u, up2, dir_b, dir_o, right_b, cam_o;
    logic               ok_d, ok_h, ok_r, ok_dh_b, ok_dh_o, ok_r_b;
    logic [3:0][2:0][CW-1:0] rows_c;
    logic [2:0][CW-1:0] back_c;
    logic               degen_c;

    assign cam_c = {i_cam_z, i_cam_y, i_cam_x};
    assign tgt_c = {i_target_z, i_target_y, i_target_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff_c[i] = {tgt_c[i][CW-1], tgt_c[i]} - {cam_c[i][CW-1], cam_c[i]};
            if (diff_c[i][CW] != diff_c[i][CW-1]) begin
                d_c[i] = diff_c[i][CW] ? MIN_V : MAX_V;
            end else begin
                d_c[i] = diff_c[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            for (int i = 0; i < T; i++) begin
                r_vp[i] <= 1'b0;
            end
        end else if (en) begin
            r_va    <= i_valid;
            r_vp[0] <= r_va;
            for (int i = 1; i < T; i++) begin
                r_vp[i] <= r_vp[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cam  <= cam_c;
            r_dvec <= d_c;
            r_hvec <= {i_hint_z, i_hint_y, i_hint_x};
        end
    end

    lacm_norm #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW)) u_norm_dir (
        .i_clk(i_clk), .i_en(en), .i_vec(r_dvec), .o_unit(dir_u), .o_nonzero(ok_d)
    );

    lacm_norm #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW)) u_norm_hint (
        .i_clk(i_clk), .i_en(en), .i_vec(r_hvec), .o_unit(up_u), .o_nonzero(ok_h)
    );

    lacm_cross #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW)) u_cross_right (
        .i_clk(i_clk), .i_en(en), .i_a(dir_u), .i_b(up_u), .o_c(rraw)
    );

    lacm_delay #(.WIDTH(3 * CW + 1), .DEPTH(CL + NL)) u_dly_dir (
        .i_clk(i_clk), .i_en(en),
        .i_data({ok_d && ok_h, dir_u}), .o_data({ok_dh_b, dir_b})
    );

    lacm_norm #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW)) u_norm_right (
        .i_clk(i_clk), .i_en(en), .i_vec(rraw), .o_unit(right_u), .o_nonzero(ok_r)
    );

    lacm_cross #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW)) u_cross_up (
        .i_clk(i_clk), .i_en(en), .i_a(right_u), .i_b(dir_b), .o_c(up2)
    );

    lacm_delay #(.WIDTH(3 * CW + 1), .DEPTH(CL)) u_dly_back (
        .i_clk(i_clk), .i_en(en),
        .i_data({ok_dh_b, dir_b}), .o_data({ok_dh_o, dir_o})
    );

    lacm_delay #(.WIDTH(3 * CW + 1), .DEPTH(CL)) u_dly_right (
        .i_clk(i_clk), .i_en(en),
        .i_data({ok_r, right_u}), .o_data({ok_r_b, right_b})
    );

    lacm_delay #(.WIDTH(3 * CW), .DEPTH(T)) u_dly_cam (
        .i_clk(i_clk), .i_en(en), .i_data(r_cam), .o_data(cam_o)
    );

    always_comb begin
        degen_c = !(ok_dh_o && ok_r_b);
        for (int i = 0; i < 3; i++) begin
            back_c[i] = (dir_o[i] == MIN_V) ? MAX_V : CW'(-dir_o[i]);
        end
        rows_c[ROW_RIGHT] = degen_c ? '0 : right_b;
        rows_c[ROW_UP]    = degen_c ? '0 : up2;
        rows_c[ROW_BACK]  = degen_c ? '0 : back_c;
        rows_c[ROW_POS]   = cam_o;
    end

    lacm_rowout #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW)) u_rowout (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_vp[T-1]),
        .i_rows(rows_c),
        .i_degen(degen_c),
        .o_take(en),
        .i_stall(i_stall),
        .o_valid(o_valid),
        .o_row_index(o_row_index),
        .o_elem_x(o_elem_x),
        .o_elem_y(o_elem_y),
        .o_elem_z(o_elem_z),
        .o_elem_w(o_elem_w),
        .o_last_row(o_last_row),
        .o_degenerate(o_degenerate)
    );

    assign o_stall = !en;

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_row_index != ROW_POS |=>
            o_valid && o_row_index == 2'($past(o_row_index) + 2'd1))
        else $error("row sequence broken");

    a_degen_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_row_index != ROW_POS |=> $stable(o_degenerate))
        else $error("degenerate flag changed within an item");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate && o_row_index != ROW_POS |->
            o_elem_x == '0 && o_elem_y == '0 && o_elem_z == '0)
        else $error("degenerate row not zero");

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lacm_pkg::*;

    localparam int CW = LACM_COORD_WIDTH;
    localparam int FB = LACM_FRAC_BITS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic signed [67:0] COORD_MAX = 68'sd2147483647;
    localparam logic signed [67:0] COORD_MIN = -68'sd2147483648;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        t_coord cam [3];
        t_coord tgt [3];
        t_coord hint [3];
    } t_view;

    typedef struct {
        t_row             row;
        t_coord           x;
        t_coord           y;
        t_coord           z;
        logic [W_WIDTH-1:0] w;
        logic             last;
        logic             degen;
    } t_row_beat;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   i_stall = 1'b0;
    t_coord i_cam_x = '0, i_cam_y = '0, i_cam_z = '0;
    t_coord i_target_x = '0, i_target_y = '0, i_target_z = '0;
    t_coord i_hint_x = '0, i_hint_y = '0, i_hint_z = '0;
    logic   o_stall, o_valid, o_last_row, o_degenerate;
    logic [1:0] o_row_index;
    t_coord o_elem_x, o_elem_y, o_elem_z;
    logic [W_WIDTH-1:0] o_elem_w;

    look_at_camera_matrix_core i_dut (.*);

    always #10 i_clk = ~i_clk;

    t_view     pending_views [$];
    t_row_beat expected_rows [$];
    int        errors = 0;
    int        rows_seen = 0;
    int        cycles = 0;

    function automatic t_coord clamp(logic signed [67:0] x);
        if (x > COORD_MAX) return COORD_MAX[CW-1:0];
        if (x < COORD_MIN) return COORD_MIN[CW-1:0];
        return x[CW-1:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit_vector(input logic signed [67:0] v [3], output t_coord u [3]);
        logic [63:0] m [3];
        logic [63:0] s, r, q, num;
        int k;
        s = 0;
        k = 0;
        for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
        while (m[0] > 64'h8000_0000 || m[1] > 64'h8000_0000 || m[2] > 64'h8000_0000)
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        if (s == 0) begin
            for (int i = 0; i < 3; i++) u[i] = '0;
            return 1'b0;
        end
        while (s < (64'h1 << 62)) begin
            s = s << 2;
            k++;
        end
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            num = m[i] << (FB + k);
            q = (num + r / 2) / r;
            u[i] = clamp((v[i] < 0) ? -$signed({4'b0, q}) : $signed({4'b0, q}));
        end
        return 1'b1;
    endfunction

    function automatic t_coord round_shift(logic signed [67:0] x);
        logic [67:0] m;
        m = (x < 0) ? 68'(-x) : 68'(x);
        m = (m + (68'h1 << (FB - 1))) >> FB;
        return clamp((x < 0) ? -$signed(m) : $signed(m));
    endfunction

    function automatic void cross_product(input t_coord a [3], input t_coord b [3],
                                          output t_coord c [3]);
        logic signed [67:0] p [3], q [3];
        for (int i = 0; i < 3; i++) begin
            p[i] = a[i];
            q[i] = b[i];
        end
        c[0] = round_shift(p[1] * q[2] - p[2] * q[1]);
        c[1] = round_shift(p[2] * q[0] - p[0] * q[2]);
        c[2] = round_shift(p[0] * q[1] - p[1] * q[0]);
    endfunction

    task automatic predict_matrix(input t_view vw);
        logic signed [67:0] d [3], h [3], rr [3];
        t_coord dir [3], up [3], rraw [3], right [3], up2 [3];
        t_coord rows [4][3];
        t_row_beat b;
        bit ok;
        for (int i = 0; i < 3; i++) begin
            d[i] = clamp(68'(vw.tgt[i]) - 68'(vw.cam[i]));
            h[i] = vw.hint[i];
        end
        ok = unit_vector(d, dir);
        ok = unit_vector(h, up) && ok;
        cross_product(dir, up, rraw);
        for (int i = 0; i < 3; i++) rr[i] = rraw[i];
        ok = unit_vector(rr, right) && ok;
        cross_product(right, dir, up2);
        for (int i = 0; i < 3; i++) begin
            rows[0][i] = ok ? right[i] : '0;
            rows[1][i] = ok ? up2[i] : '0;
            rows[2][i] = ok ? clamp(-68'(dir[i])) : '0;
            rows[3][i] = vw.cam[i];
        end
        for (int k = 0; k < 4; k++) begin
            b.row   = t_row'(k);
            b.x     = rows[k][0];
            b.y     = rows[k][1];
            b.z     = rows[k][2];
            b.w     = (k == 3) ? W_WIDTH'(1 << FB) : '0;
            b.last  = (k == 3);
            b.degen = !ok;
            expected_rows.push_back(b);
        end
    endtask

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return t_coord'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return t_coord'($signed($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    function automatic t_view make_view(t_coord c0, t_coord c1, t_coord c2, t_coord t0,
                                        t_coord t1, t_coord t2, t_coord h0, t_coord h1,
                                        t_coord h2);
        t_view v;
        v.cam  = '{c0, c1, c2};
        v.tgt  = '{t0, t1, t2};
        v.hint = '{h0, h1, h2};
        return v;
    endfunction

    // Driver: bursts of random length separated by random gaps.
    t_view cur_view;
    int    gap_left = 0;
    int    burst_left = 1;

    always @(posedge i_clk) begin
        logic nv;
        nv = 1'b0;
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (i_valid) predict_matrix(cur_view);
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_views.size() > 0) begin
                cur_view = pending_views.pop_front();
                nv = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            i_valid    <= nv;
            i_cam_x    <= cur_view.cam[0];
            i_cam_y    <= cur_view.cam[1];
            i_cam_z    <= cur_view.cam[2];
            i_target_x <= cur_view.tgt[0];
            i_target_y <= cur_view.tgt[1];
            i_target_z <= cur_view.tgt[2];
            i_hint_x   <= cur_view.hint[0];
            i_hint_y   <= cur_view.hint[1];
            i_hint_z   <= cur_view.hint[2];
        end
    end

    // Monitor and receiver stall pattern, with one long hold-off.
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_row_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            rows_seen++;
            if (expected_rows.size() == 0) begin
                $error("unexpected row beat, row_index %0d", o_row_index);
                errors++;
            end else begin
                e = expected_rows.pop_front();
                if (o_row_index !== e.row) begin
                    $error("row_index: expected %0d, got %0d", e.row, o_row_index);
                    errors++;
                end
                if (o_elem_x !== e.x) begin
                    $error("elem_x: expected %0d, got %0d", e.x, o_elem_x);
                    errors++;
                end
                if (o_elem_y !== e.y) begin
                    $error("elem_y: expected %0d, got %0d", e.y, o_elem_y);
                    errors++;
                end
                if (o_elem_z !== e.z) begin
                    $error("elem_z: expected %0d, got %0d", e.z, o_elem_z);
                    errors++;
                end
                if (o_elem_w !== e.w) begin
                    $error("elem_w: expected %0d, got %0d", e.w, o_elem_w);
                    errors++;
                end
                if (o_last_row !== e.last) begin
                    $error("last_row: expected %0d, got %0d", e.last, o_last_row);
                    errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate: expected %0d, got %0d", e.degen, o_degenerate);
                    errors++;
                end
            end
        end
        if (!hold_done && rows_seen >= 60) begin
            hold_done = 1'b1;
            hold_left = 800;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("look_at_camera_matrix_core regression: fail");
            $finish;
        end
    end

    initial begin
        t_coord mx, mn, one;
        int mode;
        mx  = COORD_MAX[CW-1:0];
        mn  = COORD_MIN[CW-1:0];
        one = t_coord'(1 << FB);
        pending_views.push_back(make_view(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
        pending_views.push_back(make_view(one, 2 * one, 3 * one, one, 2 * one, 3 * one,
                                          0, one, 0));
        pending_views.push_back(make_view(0, 0, 0, one, 0, 0, 0, 0, 0));
        pending_views.push_back(make_view(0, 0, 0, 0, one, 0, 0, 3 * one, 0));
        pending_views.push_back(make_view(0, 0, 0, one, one, 0, -one, -one, 0));
        pending_views.push_back(make_view(mn, mn, mn, mx, mx, mx, 0, one, 0));
        pending_views.push_back(make_view(mx, mx, mx, mn, mn, mn, mx, 0, mn));
        pending_views.push_back(make_view(mn, mx, mn, mn, mx, mx, mn, mn, mn));
        pending_views.push_back(make_view(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        pending_views.push_back(make_view(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        pending_views.push_back(make_view(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_views.push_back(make_view(0, 0, 0, 1, 1, 1, 1, -1, 0));
        pending_views.push_back(make_view(0, 0, 0, 0, 0, -one, mx, mx, 0));
        pending_views.push_back(make_view(0, 0, 0, 0, 0, mx, 0, mn, 0));
        pending_views.push_back(make_view(-1, -1, -1, mx, 0, 0, 0, 0, 1));
        pending_views.push_back(make_view(3, 0, 0, 0, 0, 0, 1, 1, 0));
        for (int n = 0; n < 154; n++) begin
            t_view v;
            mode = $urandom_range(0, 9);
            for (int i = 0; i < 3; i++) begin
                v.cam[i]  = rand_coord(mode < 2 ? 0 : 2);
                v.tgt[i]  = (mode < 2) ? rand_coord(0) : v.cam[i] + rand_coord(mode % 4);
                v.hint[i] = rand_coord(mode % 4);
            end
            if (mode == 9) v.tgt = v.cam;
            if (mode == 8) v.hint = '{0, 0, 0};
            pending_views.push_back(v);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_views.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_rows.size() == 0) begin
            $display("look_at_camera_matrix_core regression: pass");
        end else begin
            $display("look_at_camera_matrix_core regression: fail");
        end
        $finish;
    end
endmodule

// ===== look_at_camera_matrix_core.f =====
hdl/lacm_pkg.sv
hdl/lacm_delay.sv
hdl/lacm_norm.sv
hdl/lacm_cross.sv
hdl/lacm_rowout.sv
hdl/look_at_camera_matrix_core.sv
sim/testbench.sv
